// ----- rtl/iobog_pkg.sv -----
`timescale 1ns / 1ps
package iobog_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned CFG_W    = 48;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned ADDR_BITS = 48;

    localparam logic [IDX_W-1:0] REG_BEGIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_END    = 3'd1;
    localparam logic [IDX_W-1:0] REG_FSIZE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BSIZE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BCOUNT = 3'd4;
    localparam logic [IDX_W-1:0] REG_WRITE  = 3'd5;
    localparam logic [IDX_W-1:0] REG_RANDOM = 3'd6;
    localparam logic [IDX_W-1:0] REG_DIRECT = 3'd7;

    localparam logic [1:0] KIND_ISSUE  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVERTED = 3'd1;
    localparam logic [2:0] ST_SIZE_MIS = 3'd2;
    localparam logic [2:0] ST_BEG_MIS  = 3'd3;
    localparam logic [2:0] ST_SMALL    = 3'd4;
    localparam logic [2:0] ST_IOERR    = 3'd5;
    localparam logic [2:0] ST_SHORT    = 3'd6;
    localparam logic [2:0] ST_IDLE     = 3'd7;

    localparam logic [63:0] LCG_SEED  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] LCG_MUL   = 64'd2862933555777941757;
    localparam logic [63:0] LCG_ADD   = 64'd3037000493;
    localparam int unsigned LCG_SHIFT = 33;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] offset;
        logic        xfer_write;
        logic [2:0]  status;
        logic [31:0] blocks_done;
        logic [55:0] bytes_total;
        logic        run_complete;
    } t_result;

    typedef struct packed {
        logic        action;
        logic [24:0] bytes_done;
        logic        io_error;
    } t_request;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_DIV = 2'b10
    } t_op;

endpackage

// ----- rtl/iobog_if.sv -----
`timescale 1ns / 1ps
interface iobog_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [24:0] bytes_done;
    logic        io_error;
    modport source (output valid, action, bytes_done, io_error, input ready);
    modport sink   (input valid, action, bytes_done, io_error, output ready);
endinterface

interface iobog_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [47:0] offset;
    logic        xfer_write;
    logic [2:0]  status;
    logic [31:0] blocks_done;
    logic [55:0] bytes_total;
    logic        run_complete;
    modport source (output valid, kind, offset, xfer_write, status, blocks_done,
                    bytes_total, run_complete, input ready);
    modport sink   (input valid, kind, offset, xfer_write, status, blocks_done,
                    bytes_total, run_complete, output ready);
endinterface

// ----- rtl/iobog_serial_unit.sv -----
`timescale 1ns / 1ps
// Bit-serial multiply (a*b mod 2^W, shift-add) or divide (restoring).
module iobog_serial_unit #(
    parameter int unsigned W = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  iobog_pkg::t_op i_op,
    input  logic [W-1:0]  i_a,
    input  logic [W-1:0]  i_b,
    output logic          o_busy,
    output logic [W-1:0]  o_res,
    output logic [W-1:0]  o_rem
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_busy, n_busy;
    iobog_pkg::t_op  r_op, n_op;
    logic [W-1:0]    r_a, n_a, r_b, n_b, r_acc, n_acc, r_q, n_q;
    logic [W:0]      w_trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_q    = r_q;
        w_trial = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_op   = i_op;
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
            n_q    = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) n_busy = 1'b0;
            unique case (r_op)
                iobog_pkg::OP_MUL: begin
                    if (r_b[0]) n_acc = r_acc + r_a;
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
                iobog_pkg::OP_DIV: begin
                    w_trial = {r_acc, r_a[W-1]} - {1'b0, r_b};
                    n_a = r_a << 1;
                    if (!w_trial[W]) begin
                        n_acc = w_trial[W-1:0];
                        n_q   = {r_q[W-2:0], 1'b1};
                    end else begin
                        n_acc = {r_acc[W-2:0], r_a[W-1]};
                        n_q   = {r_q[W-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_op   <= iobog_pkg::OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_q   <= n_q;
    end

    assign o_busy = r_busy;
    assign o_res  = (r_op == iobog_pkg::OP_DIV) ? r_q : r_acc;
    assign o_rem  = r_acc;
endmodule

// ----- rtl/io_block_offset_generator_core.sv -----
`timescale 1ns / 1ps
// io_block_offset_generator_core
// Request channel (action, bytes_done, io_error): action 0 checks the
// configured region and starts a run, action 1 reports the last transfer.
// Result channel: one item per request with kind, offset, status and
// running totals. Registers are written through i_cfg_we/i_cfg_idx/
// i_cfg_data; the user must do so only while the block is idle, as the
// block itself does not enforce it. Each request is handled alone by a
// sequencer around one shared bit-serial 64-bit multiply/divide unit. A
// start takes up to six operations (default end, range division, LCG
// step, modulo, offset, byte total); a completion up to four (LCG step,
// modulo, offset, total). One request is in flight at a time.
// The result sits in an output register; the next request is taken only
// after the result is delivered, so a stalled receiver holds the block.
// Synchronous active-low reset clears the run state and seeds the LCG;
// registers return to their defaults (block size 4096, count 1).
module io_block_offset_generator_core #(
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [iobog_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [iobog_pkg::CFG_W-1:0]     i_cfg_data,
    iobog_req_if.sink                       s_req,
    iobog_res_if.source                     m_res
);
    localparam int unsigned PG_W = $clog2(PAGE_BYTES);
    localparam logic [63:0] AMASK = (iobog_pkg::ADDR_BITS >= 64) ? '1 :
                                    ((64'd1 << iobog_pkg::ADDR_BITS) - 64'd1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DEFEND = 10'b0000000010,
        S_CHECK  = 10'b0000000100,
        S_DIVR   = 10'b0000001000,
        S_LCG    = 10'b0000010000,
        S_MOD    = 10'b0000100000,
        S_OFFS   = 10'b0001000000,
        S_TOTAL  = 10'b0010000000,
        S_WAITU  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    logic [47:0] r_begin, r_end, r_fsize;
    logic [24:0] r_bsize;
    logic [31:0] r_bcount;
    logic        r_write, r_random, r_direct;

    t_state      r_st, r_ret;
    logic [63:0] r_lcg;
    logic        r_running;
    logic [47:0] r_bir;
    logic [31:0] r_eff, r_issue, r_done;
    logic [63:0] r_endv, r_idx;
    logic        r_is_start;
    iobog_pkg::t_result r_res;
    logic        r_ovalid;

    logic        u_start, u_busy;
    iobog_pkg::t_op u_op;
    logic [63:0] u_a, u_b, u_res, u_rem;

    iobog_serial_unit #(.W(64)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(u_start), .i_op(u_op),
        .i_a(u_a), .i_b(u_b), .o_busy(u_busy), .o_res(u_res), .o_rem(u_rem)
    );

    logic        w_acc;
    logic [47:0] w_usable;
    logic [63:0] w_n;
    assign w_acc    = s_req.valid && s_req.ready;
    assign s_req.ready = (r_st == S_IDLE) && !r_ovalid;
    assign w_usable = r_endv[47:0] - r_begin;
    assign w_n      = (r_bir == '0) ? 64'd1 : {16'd0, r_bir};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= '0; r_end <= '0; r_fsize <= '0;
            r_bsize <= 25'd4096; r_bcount <= 32'd1;
            r_write <= 1'b0; r_random <= 1'b0; r_direct <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iobog_pkg::REG_BEGIN:  r_begin  <= i_cfg_data;
                iobog_pkg::REG_END:    r_end    <= i_cfg_data;
                iobog_pkg::REG_FSIZE:  r_fsize  <= i_cfg_data;
                iobog_pkg::REG_BSIZE:  r_bsize  <= i_cfg_data[24:0];
                iobog_pkg::REG_BCOUNT: r_bcount <= i_cfg_data[31:0];
                iobog_pkg::REG_WRITE:  r_write  <= i_cfg_data[0];
                iobog_pkg::REG_RANDOM: r_random <= i_cfg_data[0];
                iobog_pkg::REG_DIRECT: r_direct <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        u_start <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ret <= S_IDLE;
            r_lcg <= iobog_pkg::LCG_SEED; r_running <= 1'b0;
            r_issue <= '0; r_done <= '0; r_ovalid <= 1'b0;
            r_is_start <= 1'b0;
            u_op <= iobog_pkg::OP_MUL; u_a <= '0; u_b <= '0;
        end else begin
            if (m_res.valid && m_res.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_acc) begin
                    r_res <= '0;
                    r_res.xfer_write <= r_write;
                    if (!s_req.action) begin
                        r_is_start <= 1'b1;
                        r_running <= 1'b0; r_issue <= '0; r_done <= '0;
                        r_endv <= {16'd0, r_end};
                        if (r_begin == '0 && r_end == '0) begin
                            if (r_write) begin
                                u_op <= iobog_pkg::OP_MUL;
                                u_a <= {39'd0, r_bsize}; u_b <= {32'd0, r_bcount};
                                u_start <= 1'b1; r_ret <= S_DEFEND; r_st <= S_WAITU;
                            end else begin
                                r_endv <= {16'd0, r_fsize}; r_st <= S_CHECK;
                            end
                        end else r_st <= S_CHECK;
                    end else begin
                        r_is_start <= 1'b0;
                        r_res.blocks_done <= r_done;
                        if (!r_running) begin
                            r_res.kind <= iobog_pkg::KIND_REJECT;
                            r_res.status <= iobog_pkg::ST_IDLE; r_st <= S_TOTAL;
                        end else if (s_req.io_error) begin
                            r_running <= 1'b0; r_res.kind <= iobog_pkg::KIND_FINISH;
                            r_res.status <= iobog_pkg::ST_IOERR; r_st <= S_TOTAL;
                        end else if (s_req.bytes_done != r_bsize) begin
                            r_running <= 1'b0; r_res.kind <= iobog_pkg::KIND_FINISH;
                            r_res.status <= iobog_pkg::ST_SHORT; r_st <= S_TOTAL;
                        end else begin
                            r_done <= r_done + 1'b1; r_issue <= r_issue + 1'b1;
                            r_res.blocks_done <= r_done + 1'b1;
                            if (r_done + 1'b1 >= r_eff) begin
                                r_running <= 1'b0; r_res.kind <= iobog_pkg::KIND_FINISH;
                                r_res.run_complete <= 1'b1; r_st <= S_TOTAL;
                            end else begin
                                r_res.kind <= iobog_pkg::KIND_ISSUE;
                                r_idx <= {32'd0, r_issue + 1'b1}; r_st <= S_LCG;
                            end
                        end
                    end
                end
                S_DEFEND: begin
                    r_endv <= (u_res > AMASK) ? AMASK : u_res;
                    r_st <= S_CHECK;
                end
                S_CHECK: begin
                    r_res.kind <= iobog_pkg::KIND_REJECT;
                    r_st <= S_TOTAL;
                    if (r_endv[47:0] < r_begin) r_res.status <= iobog_pkg::ST_INVERTED;
                    else if (r_bsize == '0) r_res.status <= iobog_pkg::ST_SIZE_MIS;
                    else if (r_direct && r_bsize[PG_W-1:0] != '0)
                        r_res.status <= iobog_pkg::ST_SIZE_MIS;
                    else if (r_direct && r_begin[PG_W-1:0] != '0)
                        r_res.status <= iobog_pkg::ST_BEG_MIS;
                    else if (w_usable < {23'd0, r_bsize}) r_res.status <= iobog_pkg::ST_SMALL;
                    else begin
                        u_op <= iobog_pkg::OP_DIV;
                        u_a <= {16'd0, w_usable}; u_b <= {39'd0, r_bsize};
                        u_start <= 1'b1; r_ret <= S_DIVR; r_st <= S_WAITU;
                    end
                end
                S_DIVR: begin
                    r_bir <= u_res[47:0];
                    if (!r_write && !r_random && {16'd0, r_bcount} > u_res[47:0]) begin
                        r_eff <= u_res[31:0];
                        if (u_res[31:0] == '0) begin
                            r_res.kind <= iobog_pkg::KIND_FINISH;
                            r_res.run_complete <= 1'b1; r_st <= S_TOTAL;
                        end else begin
                            r_res.kind <= iobog_pkg::KIND_ISSUE; r_running <= 1'b1;
                            r_idx <= '0; r_st <= S_LCG;
                        end
                    end else begin
                        r_eff <= r_bcount;
                        if (r_bcount == '0) begin
                            r_res.kind <= iobog_pkg::KIND_FINISH;
                            r_res.run_complete <= 1'b1; r_st <= S_TOTAL;
                        end else begin
                            r_res.kind <= iobog_pkg::KIND_ISSUE; r_running <= 1'b1;
                            r_idx <= '0; r_st <= S_LCG;
                        end
                    end
                end
                S_LCG: begin
                    u_op <= iobog_pkg::OP_MUL;
                    u_a <= r_lcg; u_b <= iobog_pkg::LCG_MUL;
                    u_start <= r_random;
                    r_ret <= S_MOD;
                    r_st <= r_random ? S_WAITU : S_MOD;
                end
                S_MOD: begin
                    u_op <= iobog_pkg::OP_DIV; u_b <= w_n;
                    if (r_random) begin
                        r_lcg <= u_res + iobog_pkg::LCG_ADD;
                        u_a <= (u_res + iobog_pkg::LCG_ADD) >> iobog_pkg::LCG_SHIFT;
                    end else u_a <= r_idx;
                    u_start <= 1'b1; r_ret <= S_OFFS; r_st <= S_WAITU;
                end
                S_OFFS: begin
                    u_op <= iobog_pkg::OP_MUL;
                    u_a <= u_rem; u_b <= {39'd0, r_bsize};
                    u_start <= 1'b1; r_ret <= S_TOTAL; r_st <= S_WAITU;
                    r_idx <= 64'd1;
                end
                S_TOTAL: begin
                    if (r_res.kind == iobog_pkg::KIND_ISSUE && r_idx == 64'd1)
                        r_res.offset <= 48'((u_res + {16'd0, r_begin}) & AMASK);
                    r_idx <= '0;
                    u_op <= iobog_pkg::OP_MUL;
                    u_a <= {32'd0, r_done}; u_b <= {39'd0, r_bsize};
                    u_start <= 1'b1; r_ret <= S_OUT; r_st <= S_WAITU;
                end
                S_WAITU: if (!u_start && !u_busy) begin
                    if (r_ret == S_OUT) r_res.bytes_total <= u_res[55:0];
                    r_st <= r_ret;
                end
                S_OUT: begin
                    if (r_is_start) r_res.blocks_done <= r_done;
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_res.valid        = r_ovalid;
    assign m_res.kind         = r_res.kind;
    assign m_res.offset       = r_res.offset;
    assign m_res.xfer_write   = r_res.xfer_write;
    assign m_res.status       = r_res.status;
    assign m_res.blocks_done  = r_res.blocks_done;
    assign m_res.bytes_total  = r_res.bytes_total;
    assign m_res.run_complete = r_res.run_complete;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_req.ready) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_res.valid && !m_res.ready) |=> m_res.valid && $stable(m_res.kind))
        else $error("result dropped");
    a_issue_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_res.valid && m_res.kind == iobog_pkg::KIND_ISSUE) |-> m_res.status == iobog_pkg::ST_OK)
        else $error("issue with error status");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state corrupt");
`endif
endmodule
